[sv/sca_pkg.sv]
// Shared types and constants of the sound channel allocator.
`timescale 1ns / 1ps

package sca_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS_IN_USE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPAT_SOUND    = 2'd1;

   localparam logic [1:0] FUNC_START    = 2'd0;
   localparam logic [1:0] FUNC_SILENCE  = 2'd1;
   localparam logic [1:0] FUNC_FINISHED = 2'd2;
   localparam logic [1:0] FUNC_STOP_ALL = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] owner_id;
      logic        pickup;
      logic [7:0]  sound_priority;
      logic [2:0]  channel;
   } req_type;

   typedef struct packed {
      logic       granted;
      logic [2:0] channel_index;
      logic       preempted;
      logic       freed_any;
   } rsp_type;

   typedef struct packed {
      logic        busy;
      logic [31:0] owner;
      logic        pickup_class;
      logic [7:0]  prio;
   } entry_type;

   typedef struct packed {
      logic kill;
      logic own;
      logic free;
      logic lower;
   } flags_type;

endpackage

[sv/sca_entry_cmp.sv]
// Shared compare unit: tests one channel entry against the current request.
`timescale 1ns / 1ps

module sca_entry_cmp
   import sca_pkg::*;
(
   input  entry_type entry,
   input  req_type   req,
   input  logic      compat,
   output flags_type flags
);

   logic owner_hit;

   assign owner_hit   = (req.owner_id != 32'd0) && entry.busy &&
                        (entry.owner == req.owner_id);
   assign flags.own   = owner_hit;
   assign flags.kill  = owner_hit && (compat || (entry.pickup_class == req.pickup));
   assign flags.free  = !entry.busy;
   assign flags.lower = entry.busy && (entry.prio < req.sound_priority);

endmodule

[sv/sound_channel_allocator_unit.sv]
// Top level of the sound channel allocator: channel table, scan sequencer, result register.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. Start, silence and
// stop-all requests walk the active channels one per cycle through a single
// shared entry compare unit (channels_in_use held to 1 .. 8); a finished
// request looks only at the channel it names. Busy is low again in the cycle
// where rsp_valid shows the result, so the next request can be accepted
// there. Every request returns exactly one result, shown for one cycle on
// rsp_data with rsp_valid; the receiver cannot stall it, so it must take it
// in that cycle. Configuration writes go through csr_we and are meant for
// idle periods only. The table resets with all channels free.
module sound_channel_allocator_unit
   import sca_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_type;

   state_type             state_ff, state_in;
   req_type               req_ff, req_in;
   logic [CH_W-1:0]       cnt_ff, cnt_in;
   logic [CH_W-1:0]       last_ff, last_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic                  kill_vld_ff, kill_vld_in;
   logic [CH_W-1:0]       kill_idx_ff, kill_idx_in;
   logic                  free_vld_ff, free_vld_in;
   logic [CH_W-1:0]       free_idx_ff, free_idx_in;
   logic                  pre_vld_ff, pre_vld_in;
   logic [CH_W-1:0]       pre_idx_ff, pre_idx_in;
   logic [MAX_CHANNELS-1:0] chan_busy_ff, chan_busy_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic [3:0]            channels_in_use_ff;
   logic                  compat_sound_ff;

   // Channel contents other than busy; only read while the channel is busy.
   logic [31:0]           owner_mem [MAX_CHANNELS];
   logic                  pickup_mem [MAX_CHANNELS];
   logic [7:0]            prio_mem [MAX_CHANNELS];

   logic                  commit_we;
   logic [CH_W-1:0]       commit_idx;

   entry_type             entry;
   flags_type             flags;
   logic [31:0]           n_clamp;

   // Clamp the configured channel count into 1 .. MAX_CHANNELS.
   always_comb begin
      n_clamp = 32'(channels_in_use_ff);
      if (n_clamp < 32'd1) begin
         n_clamp = 32'd1;
      end
      if (n_clamp > 32'(MAX_CHANNELS)) begin
         n_clamp = 32'(MAX_CHANNELS);
      end
   end

   // Present the entry under the scan pointer to the shared compare unit.
   assign entry.busy         = chan_busy_ff[cnt_ff];
   assign entry.owner        = owner_mem[cnt_ff];
   assign entry.pickup_class = pickup_mem[cnt_ff];
   assign entry.prio         = prio_mem[cnt_ff];

   sca_entry_cmp u_cmp (
      .entry  (entry),
      .req    (req_ff),
      .compat (compat_sound_ff),
      .flags  (flags)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      n_in         = n_ff;
      kill_vld_in  = kill_vld_ff;
      kill_idx_in  = kill_idx_ff;
      free_vld_in  = free_vld_ff;
      free_idx_in  = free_idx_ff;
      pre_vld_in   = pre_vld_ff;
      pre_idx_in   = pre_idx_ff;
      chan_busy_in = chan_busy_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      commit_we    = 1'b0;
      commit_idx   = free_idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               // Latch the request and the scan range, clear the scan results.
               req_in      = req_data;
               n_in        = CNT_W'(n_clamp);
               last_in     = CH_W'(n_clamp - 32'd1);
               kill_vld_in = 1'b0;
               free_vld_in = 1'b0;
               pre_vld_in  = 1'b0;
               kill_idx_in = '0;
               free_idx_in = '0;
               pre_idx_in  = '0;
               if (req_data.func == FUNC_FINISHED) begin
                  cnt_in = CH_W'(req_data.channel);
               end else begin
                  cnt_in = '0;
               end
               state_in = S_SCAN;
            end
         end

         S_SCAN: begin
            case (req_ff.func)
               FUNC_START: begin
                  // Drop the first same-owner, same-class (or compat) channel; it is free.
                  if (flags.kill && !kill_vld_ff) begin
                     chan_busy_in[cnt_ff] = 1'b0;
                     kill_vld_in          = 1'b1;
                     kill_idx_in          = cnt_ff;
                     if (!free_vld_ff) begin
                        free_vld_in = 1'b1;
                        free_idx_in = cnt_ff;
                     end
                  end else if (flags.free && !free_vld_ff) begin
                     free_vld_in = 1'b1;
                     free_idx_in = cnt_ff;
                  end
                  if (flags.lower && !pre_vld_ff) begin
                     pre_vld_in = 1'b1;
                     pre_idx_in = cnt_ff;
                  end
               end
               FUNC_SILENCE: begin
                  if (flags.own && !kill_vld_ff) begin
                     chan_busy_in[cnt_ff] = 1'b0;
                     kill_vld_in          = 1'b1;
                     kill_idx_in          = cnt_ff;
                  end
               end
               FUNC_FINISHED: begin
                  if ((32'(req_ff.channel) < 32'(n_ff)) && entry.busy) begin
                     chan_busy_in[cnt_ff] = 1'b0;
                     kill_vld_in          = 1'b1;
                     kill_idx_in          = cnt_ff;
                  end
               end
               default: begin
                  // Stop all: free every busy channel in range.
                  if (entry.busy) begin
                     chan_busy_in[cnt_ff] = 1'b0;
                     kill_vld_in          = 1'b1;
                  end
               end
            endcase

            if ((req_ff.func == FUNC_FINISHED) || (cnt_ff == last_ff)) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + CH_W'(1);
            end
         end

         S_DONE: begin
            rsp_valid_in          = 1'b1;
            rsp_in.granted        = 1'b0;
            rsp_in.channel_index  = '0;
            rsp_in.preempted      = 1'b0;
            rsp_in.freed_any      = kill_vld_ff;
            if (req_ff.func == FUNC_START) begin
               if (free_vld_ff) begin
                  commit_we   = 1'b1;
                  commit_idx  = free_idx_ff;
               end else if (pre_vld_ff) begin
                  commit_we        = 1'b1;
                  commit_idx       = pre_idx_ff;
                  rsp_in.preempted = 1'b1;
                  rsp_in.freed_any = 1'b1;
               end
               if (commit_we) begin
                  chan_busy_in[commit_idx] = 1'b1;
                  rsp_in.granted           = 1'b1;
                  rsp_in.channel_index     = 3'(commit_idx);
               end
            end else if ((req_ff.func != FUNC_STOP_ALL) && kill_vld_ff) begin
               rsp_in.channel_index = 3'(kill_idx_ff);
            end
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chan_busy_ff <= '0;
         rsp_valid_ff <= 1'b0;
         kill_vld_ff  <= 1'b0;
         free_vld_ff  <= 1'b0;
         pre_vld_ff   <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         chan_busy_ff <= chan_busy_in;
         rsp_valid_ff <= rsp_valid_in;
         kill_vld_ff  <= kill_vld_in;
         free_vld_ff  <= free_vld_in;
         pre_vld_ff   <= pre_vld_in;
         cnt_ff       <= cnt_in;
      end
      req_ff      <= req_in;
      last_ff     <= last_in;
      n_ff        <= n_in;
      kill_idx_ff <= kill_idx_in;
      free_idx_ff <= free_idx_in;
      pre_idx_ff  <= pre_idx_in;
      rsp_ff      <= rsp_in;
   end

   // Write the new owner, class and priority of the channel taken by a start.
   always_ff @(posedge clock) begin
      if (commit_we) begin
         owner_mem[commit_idx]  <= req_ff.owner_id;
         pickup_mem[commit_idx] <= req_ff.pickup;
         prio_mem[commit_idx]   <= req_ff.sound_priority;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         channels_in_use_ff <= 4'd8;
         compat_sound_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CHANNELS_IN_USE: channels_in_use_ff <= csr_wdata[3:0];
            CSR_COMPAT_SOUND:    compat_sound_ff    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_start_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_DONE))
      else $error("result strobe without a finished scan");

   a_preempt_granted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.preempted) |-> (rsp_data.granted && rsp_data.freed_any))
      else $error("preemption reported without a grant");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && req_ff.func != FUNC_FINISHED) |-> (cnt_ff <= last_ff))
      else $error("scan pointer beyond the active channels");

endmodule
